// ===== sv/slse_pkg.sv =====
// Package: types and constants for the shifted-lognormal size effect block.
`default_nettype none
package slse_pkg;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_EVAL  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    SEL_MIN    = 2'd0,
    SEL_SHIFT  = 2'd1,
    SEL_MODE   = 2'd2,
    SEL_SPREAD = 2'd3
  } psel_t;

  localparam int InWidth  = 56;
  localparam int OutWidth = 24;

  localparam logic [27:0] LN2_Q28 = 28'd186065279;
  localparam logic [28:0] E1_Q30  = 29'd395007543;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam int ExpTerms = 14;
  localparam int MaxPow   = 19;

  typedef struct packed {
    logic vld;
    logic err;
    logic zero;
  } ctl_t;

  typedef struct packed {
    ctl_t               c;
    logic [15:0]        x;
    logic [4:0]         n;
    logic signed [32:0] sum;
    logic [30:0]        p;
    logic [30:0]        q;
  } ex_t;

  typedef struct packed {
    ctl_t        c;
    logic [4:0]  n;
    logic [30:0] r;
  } mul_t;

endpackage
`default_nettype wire

// ===== sv/slse_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module slse_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ===== sv/shifted_lognormal_size_effect.sv =====
// Top level: per-species shifted-lognormal size effect, fully pipelined.
// Throughput: one transaction per cycle; the pipeline advances whenever the
// output register is empty or being taken, so parameter tables, log, divide
// and exp stages all run one item per clock.
// Reset: rst_n synchronous active low clears valid bits; tables are not cleared.
`default_nettype none
module shifted_lognormal_size_effect #(
  parameter int SPECIES = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // species[4:0] param_select[6:5] param_value[30:7] diameter[53:31]
  input  wire logic [slse_pkg::InWidth-1:0]  in_tdata,
  // req_type
  input  wire logic                          in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // size_effect[16:0]
  output logic [slse_pkg::OutWidth-1:0]      out_tdata,
  // domain_error
  output logic                               out_tuser
);
  import slse_pkg::*;

  localparam int AW = (SPECIES > 1) ? $clog2(SPECIES) : 1;

  function automatic logic [4:0] msb25(input logic [24:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < 25; i++) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

  logic en, acc, oor;
  logic [4:0]  sp;
  logic [1:0]  psel;
  logic [23:0] pval;
  logic [22:0] dia;
  logic [AW-1:0] addr;
  logic we_min, we_sh, we_mode, we_spr;
  logic [23:0] q_min, q_sh, q_mode, q_spr;

  logic        out_tvalid_r;
  logic [16:0] out_se_r;
  logic        out_err_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;
  assign acc       = in_tvalid && en;
  assign sp        = in_tdata[4:0];
  assign psel      = in_tdata[6:5];
  assign pval      = in_tdata[30:7];
  assign dia       = in_tdata[53:31];
  assign oor       = {4'b0, sp} >= 9'(SPECIES);
  assign addr      = AW'(sp);

  always_comb begin
    we_min  = 1'b0;
    we_sh   = 1'b0;
    we_mode = 1'b0;
    we_spr  = 1'b0;
    if (acc && in_tuser == REQ_WRITE && !oor) begin
      unique case (psel)
        SEL_MIN:    we_min  = 1'b1;
        SEL_SHIFT:  we_sh   = 1'b1;
        SEL_MODE:   we_mode = 1'b1;
        SEL_SPREAD: we_spr  = 1'b1;
        default:    we_min  = 1'b0;
      endcase
    end
  end

  slse_ram #(.WIDTH(24), .DEPTH(SPECIES)) u_min (
    .clk, .we(we_min), .waddr(addr), .wdata(pval), .re(en), .raddr(addr), .rdata(q_min));
  slse_ram #(.WIDTH(24), .DEPTH(SPECIES)) u_shift (
    .clk, .we(we_sh), .waddr(addr), .wdata(pval), .re(en), .raddr(addr), .rdata(q_sh));
  slse_ram #(.WIDTH(24), .DEPTH(SPECIES)) u_mode (
    .clk, .we(we_mode), .waddr(addr), .wdata(pval), .re(en), .raddr(addr), .rdata(q_mode));
  slse_ram #(.WIDTH(24), .DEPTH(SPECIES)) u_spread (
    .clk, .we(we_spr), .waddr(addr), .wdata(pval), .re(en), .raddr(addr), .rdata(q_spr));

  // stage 0: request capture alongside table read
  ctl_t        s0_c_r;
  logic [22:0] s0_dia_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_c_r <= '0;
    end else if (en) begin
      s0_c_r <= '{vld: acc && in_tuser == REQ_EVAL, err: oor, zero: oor};
    end
  end

  always_ff @(posedge clk) begin
    if (en) s0_dia_r <= dia;
  end

  // stage 1: clamp, shift, domain checks
  logic signed [24:0] dia_s, dmin_s, dmx;
  logic signed [25:0] asum;
  logic               bad1;
  ctl_t               s1_c_r;
  logic [24:0]        s1_a_r;
  logic [22:0]        s1_m_r;
  logic [23:0]        s1_sa_r;

  always_comb begin
    dia_s  = $signed({2'b00, s0_dia_r});
    dmin_s = $signed({q_min[23], q_min});
    dmx    = (dia_s < dmin_s) ? dmin_s : dia_s;
    asum   = $signed({dmx[24], dmx}) + $signed({{2{q_sh[23]}}, q_sh});
    bad1   = (asum <= 26'sd0) || ($signed(q_mode) <= 24'sd0) || (q_spr == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_c_r <= '0;
    end else if (en) begin
      s1_c_r <= '{vld: s0_c_r.vld, err: s0_c_r.err | bad1, zero: s0_c_r.zero | bad1};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r  <= asum[24:0];
      s1_m_r  <= q_mode[22:0];
      s1_sa_r <= q_spr[23] ? (~q_spr + 24'd1) : q_spr;
    end
  end

  // stage 2 and log stages: normalize, then one squaring per stage
  logic [4:0]  ka, km;
  ctl_t        lg_c_r  [0:30];
  logic [30:0] lg_ya_r [0:30];
  logic [30:0] lg_ym_r [0:30];
  logic [29:0] lg_fa_r [0:30];
  logic [29:0] lg_fm_r [0:30];
  logic [4:0]  lg_ka_r [0:30];
  logic [4:0]  lg_km_r [0:30];
  logic [23:0] lg_sa_r [0:30];

  assign ka = msb25(s1_a_r);
  assign km = msb25({2'b00, s1_m_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_c_r[0] <= '0;
    end else if (en) begin
      lg_c_r[0] <= s1_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lg_ya_r[0] <= {6'b0, s1_a_r} << (5'd30 - ka);
      lg_ym_r[0] <= {8'b0, s1_m_r} << (5'd30 - km);
      lg_fa_r[0] <= '0;
      lg_fm_r[0] <= '0;
      lg_ka_r[0] <= ka;
      lg_km_r[0] <= km;
      lg_sa_r[0] <= s1_sa_r;
    end
  end

  for (genvar j = 0; j < 30; j++) begin : g_log
    logic [61:0] sqa, sqm;
    logic [31:0] ta, tm;
    assign sqa = 62'(lg_ya_r[j]) * 62'(lg_ya_r[j]);
    assign sqm = 62'(lg_ym_r[j]) * 62'(lg_ym_r[j]);
    assign ta  = sqa[61:30];
    assign tm  = sqm[61:30];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lg_c_r[j+1] <= '0;
      end else if (en) begin
        lg_c_r[j+1] <= lg_c_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lg_ya_r[j+1] <= ta[31] ? ta[31:1] : ta[30:0];
        lg_ym_r[j+1] <= tm[31] ? tm[31:1] : tm[30:0];
        lg_fa_r[j+1] <= lg_fa_r[j] | ({29'b0, ta[31]} << (29 - j));
        lg_fm_r[j+1] <= lg_fm_r[j] | ({29'b0, tm[31]} << (29 - j));
        lg_ka_r[j+1] <= lg_ka_r[j];
        lg_km_r[j+1] <= lg_km_r[j];
        lg_sa_r[j+1] <= lg_sa_r[j];
      end
    end
  end

  // log difference, scale by ln2, form dividend and divisor
  logic signed [35:0] ldiff;
  logic [62:0]        ltot;
  ctl_t               mg_c_r, pp_c_r, ln_c_r, nd_c_r;
  logic [34:0]        mag_r;
  logic [23:0]        mg_sa_r, pp_sa_r, ln_sa_r;
  logic [45:0]        ph_r;
  logic [44:0]        pl_r;
  logic [34:0]        lnq_r;
  logic [35:0]        nd_n_r;
  logic [25:0]        nd_d_r;

  assign ldiff = $signed({1'b0, lg_ka_r[30], lg_fa_r[30]})
               - $signed({1'b0, lg_km_r[30], lg_fm_r[30]});
  assign ltot  = {ph_r, 17'b0} + 63'(pl_r) + (63'd1 << 27);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mg_c_r <= '0;
      pp_c_r <= '0;
      ln_c_r <= '0;
      nd_c_r <= '0;
    end else if (en) begin
      mg_c_r <= lg_c_r[30];
      pp_c_r <= mg_c_r;
      ln_c_r <= pp_c_r;
      nd_c_r <= ln_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= ldiff[35] ? 35'(-ldiff) : ldiff[34:0];
      mg_sa_r <= lg_sa_r[30];
      ph_r    <= 46'(mag_r[34:17]) * 46'(LN2_Q28);
      pl_r    <= 45'(mag_r[16:0]) * 45'(LN2_Q28);
      pp_sa_r <= mg_sa_r;
      lnq_r   <= ltot[62:28];
      ln_sa_r <= pp_sa_r;
      nd_n_r  <= 36'(lnq_r) + 36'({ln_sa_r, 1'b0});
      nd_d_r  <= {ln_sa_r, 2'b00};
    end
  end

  // quotient range check, then restoring division one bit per stage
  logic        ovf;
  ctl_t        dv_c_r   [0:20];
  logic [35:0] dv_rem_r [0:20];
  logic [25:0] dv_d_r   [0:20];
  logic [19:0] dv_q_r   [0:20];

  assign ovf = {10'b0, nd_n_r} >= {nd_d_r, 20'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_c_r[0] <= '0;
    end else if (en) begin
      dv_c_r[0] <= '{vld: nd_c_r.vld, err: nd_c_r.err, zero: nd_c_r.zero | ovf};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0] <= nd_n_r;
      dv_d_r[0]   <= nd_d_r;
      dv_q_r[0]   <= '0;
    end
  end

  for (genvar j = 0; j < 20; j++) begin : g_div
    logic [45:0] dsh;
    logic [45:0] rem_w;
    logic        ge;
    assign dsh   = 46'(dv_d_r[j]) << (19 - j);
    assign rem_w = 46'(dv_rem_r[j]);
    assign ge    = rem_w >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_c_r[j+1] <= '0;
      end else if (en) begin
        dv_c_r[j+1] <= dv_c_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[j+1] <= ge ? 36'(rem_w - dsh) : dv_rem_r[j];
        dv_q_r[j+1]   <= dv_q_r[j] | ({19'b0, ge} << (19 - j));
        dv_d_r[j+1]   <= dv_d_r[j];
      end
    end
  end

  // square and halve, split into integer and fraction
  logic [40:0] usq;
  logic [23:0] vq;
  logic        big;
  ex_t         ex_a_r [1:ExpTerms];
  ex_t         ex_b_r [1:ExpTerms];
  ex_t         ex_c_r [0:ExpTerms];

  assign usq = 41'(dv_q_r[20]) * 41'(dv_q_r[20]) + (41'd1 << 16);
  assign vq  = usq[40:17];
  assign big = vq >= (24'd20 << 16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_c_r[0].c <= '0;
    end else if (en) begin
      ex_c_r[0].c <= '{vld: dv_c_r[20].vld, err: dv_c_r[20].err,
                       zero: dv_c_r[20].zero | big};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex_c_r[0].x   <= vq[15:0];
      ex_c_r[0].n   <= vq[20:16];
      ex_c_r[0].sum <= 33'(ONE_Q30);
      ex_c_r[0].p   <= ONE_Q30;
      ex_c_r[0].q   <= '0;
    end
  end

  // Taylor series of exp(-x): term product, reciprocal, correction per term
  for (genvar i = 1; i <= ExpTerms; i++) begin : g_exp
    localparam int I = i;
    localparam logic [31:0] RCP = 32'((64'd1 << 31) / I);
    logic [46:0] pa;
    logic [62:0] pb;
    logic [34:0] rm;
    logic [30:0] term;
    ex_t         a_nxt, b_nxt, c_nxt;

    always_comb begin
      pa    = 47'(ex_c_r[i-1].p) * 47'(ex_c_r[i-1].x);
      a_nxt = ex_c_r[i-1];
      a_nxt.p = pa[46:16];

      pb    = 63'(ex_a_r[i].p) * 63'(RCP);
      b_nxt = ex_a_r[i];
      b_nxt.q = pb[61:31];

      rm    = 35'(ex_b_r[i].p) - 35'(ex_b_r[i].q) * 35'(I);
      term  = (rm >= 35'(I)) ? ex_b_r[i].q + 31'd1 : ex_b_r[i].q;
      c_nxt = ex_b_r[i];
      c_nxt.p = term;
      c_nxt.sum = (I % 2 == 1) ? ex_b_r[i].sum - $signed(33'(term))
                               : ex_b_r[i].sum + $signed(33'(term));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ex_a_r[i].c <= '0;
        ex_b_r[i].c <= '0;
        ex_c_r[i].c <= '0;
      end else if (en) begin
        ex_a_r[i] <= a_nxt;
        ex_b_r[i] <= b_nxt;
        ex_c_r[i] <= c_nxt;
      end
    end
  end

  // integer part: multiply by exp(-1) once per stage while stage < n
  mul_t mr_r [0:MaxPow];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mr_r[0].c <= '0;
    end else if (en) begin
      mr_r[0].c <= ex_c_r[ExpTerms].c;
      mr_r[0].n <= ex_c_r[ExpTerms].n;
      mr_r[0].r <= ex_c_r[ExpTerms].sum[32] ? '0 : ex_c_r[ExpTerms].sum[30:0];
    end
  end

  for (genvar k = 0; k < MaxPow; k++) begin : g_pow
    logic [60:0] pm;
    mul_t        m_nxt;

    always_comb begin
      pm    = 61'(mr_r[k].r) * 61'(E1_Q30) + (61'd1 << 29);
      m_nxt = mr_r[k];
      if (mr_r[k].n > 5'(k)) m_nxt.r = pm[60:30];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mr_r[k+1].c <= '0;
      end else if (en) begin
        mr_r[k+1] <= m_nxt;
      end
    end
  end

  // rounding, clamp, output register
  logic [31:0] rr;
  logic [17:0] res18;
  logic [16:0] se_nxt;

  always_comb begin
    rr     = {1'b0, mr_r[MaxPow].r} + (32'd1 << 13);
    res18  = rr[31:14];
    se_nxt = (res18 > 18'd65536) ? 17'd65536 : res18[16:0];
    if (mr_r[MaxPow].c.zero) se_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= mr_r[MaxPow].c.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_se_r  <= se_nxt;
      out_err_r <= mr_r[MaxPow].c.err;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, out_se_r};
  assign out_tuser  = out_err_r;
endmodule
`default_nettype wire

// ===== tb/slse_checker.sv =====
// Checker: predicts size effect results from observed input transactions and compares outputs.
`timescale 1ns / 1ps
module slse_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  input  wire logic                          in_tready,
  input  wire logic [slse_pkg::InWidth-1:0]  in_tdata,
  input  wire logic                          in_tuser,
  input  wire logic                          out_tvalid,
  input  wire logic                          out_tready,
  input  wire logic [slse_pkg::OutWidth-1:0] out_tdata,
  input  wire logic                          out_tuser,
  output int                                 fail_count,
  output int                                 pending
);
  import slse_pkg::*;

  typedef struct packed {
    logic [16:0] effect;
    logic        err;
  } effect_t;

  logic signed [23:0] min_tab [32];
  logic signed [23:0] shift_tab [32];
  logic signed [23:0] mode_tab [32];
  logic signed [23:0] spread_tab [32];
  effect_t expected_q[$];

  function automatic longint unsigned log2_fix(longint unsigned n);
    int k;
    longint unsigned y, frac;
    k = 0;
    frac = 0;
    while (k < 62 && (n >> (k + 1)) != 0) k++;
    y = (k <= 30) ? (n << (30 - k)) : (n >> (k - 30));
    for (int i = 0; i < 30; i++) begin
      y = (y * y) >> 30;
      if (y >= 64'h8000_0000) begin
        y = y >> 1;
        frac |= 64'd1 << (29 - i);
      end
    end
    return (longint'(k) << 30) | frac;
  endfunction

  function automatic longint unsigned exp_neg(longint unsigned x);
    longint unsigned term;
    longint sum;
    term = 64'd1 << 30;
    sum = 64'sd1 << 30;
    for (int i = 1; i <= 14; i++) begin
      term = ((term * x) >> 16) / i;
      if (i % 2) sum -= longint'(term);
      else sum += longint'(term);
    end
    return sum < 0 ? 0 : longint'(sum);
  endfunction

  function automatic effect_t size_effect(logic [4:0] sp, logic [22:0] dia);
    longint diam, a, m, s, diff;
    longint unsigned mag, lnq, sa, uq, vq, r, e1, res;
    effect_t e;
    e.effect = '0;
    e.err = 1'b1;
    diam = longint'(dia);
    if (diam < min_tab[sp]) diam = min_tab[sp];
    a = diam + shift_tab[sp];
    m = mode_tab[sp];
    s = spread_tab[sp];
    if (a <= 0 || m <= 0 || s == 0) return e;
    e.err = 1'b0;
    diff = longint'(log2_fix(a)) - longint'(log2_fix(m));
    mag = diff < 0 ? -diff : diff;
    lnq = (mag * 64'd186065279 + (64'd1 << 27)) >> 28;
    sa = s < 0 ? -s : s;
    uq = (lnq + 2 * sa) / (4 * sa);
    if (uq >= (64'd1 << 20)) return e;
    vq = (uq * uq + (64'd1 << 16)) >> 17;
    if (vq >= (64'd20 << 16)) return e;
    r = exp_neg(vq & 64'hFFFF);
    e1 = exp_neg(64'd65536);
    for (int k = 0; k < int'(vq >> 16); k++) r = (r * e1 + (64'd1 << 29)) >> 30;
    res = (r + (64'd1 << 13)) >> 14;
    if (res > 65536) res = 65536;
    e.effect = res[16:0];
    return e;
  endfunction

  task automatic report(string what, effect_t got, effect_t want);
    $display("mismatch %s: got %0d/%0b want %0d/%0b", what, got.effect, got.err,
             want.effect, want.err);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    effect_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (in_tuser == REQ_WRITE) begin
          case (psel_t'(in_tdata[6:5]))
            SEL_MIN:    min_tab[in_tdata[4:0]] <= in_tdata[30:7];
            SEL_SHIFT:  shift_tab[in_tdata[4:0]] <= in_tdata[30:7];
            SEL_MODE:   mode_tab[in_tdata[4:0]] <= in_tdata[30:7];
            SEL_SPREAD: spread_tab[in_tdata[4:0]] <= in_tdata[30:7];
          endcase
        end else begin
          expected_q.push_back(size_effect(in_tdata[4:0], in_tdata[53:31]));
        end
      end
      if (out_tvalid && out_tready) begin
        got.effect = out_tdata[16:0];
        got.err = out_tuser;
        if (expected_q.size() == 0) begin
          report("unexpected transaction", got, got);
        end else begin
          want = expected_q.pop_front();
          if (got.effect != want.effect || out_tdata[23:17] != 0)
            report("size_effect", got, want);
          if (got.err != want.err) report("domain_error", got, want);
        end
      end
    end
    pending <= expected_q.size();
  end
endmodule

// ===== tb/tb_top.sv =====
// Testbench top: clock, reset, stimulus and verdict for the size effect block.
`timescale 1ns / 1ps
module tb_top;
  import slse_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [InWidth-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OutWidth-1:0] out_tdata;
  logic out_tuser;
  int fail_count, pending;
  int cycles = 0;
  int send_idle = 8, recv_idle = 45;
  logic [31:0] written [32];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  shifted_lognormal_size_effect uut (.*);

  slse_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_tready <= ($urandom_range(99) >= recv_idle);
    if (cycles > 400000) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic send(logic kind, logic [4:0] sp, psel_t sel, logic [23:0] val,
                      logic [22:0] dia);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {2'b0, dia, val, sel, sp};
    if (kind == REQ_WRITE) written[sp][sel] = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write(logic [4:0] sp, psel_t sel, logic [23:0] val);
    send(REQ_WRITE, sp, sel, val, '0);
  endtask

  task automatic evaluate(logic [4:0] sp, logic [22:0] dia);
    if (written[sp][3:0] == 4'hF) send(REQ_EVAL, sp, SEL_MIN, 24'($urandom), dia);
  endtask

  task automatic load_row(logic [4:0] sp);
    write(sp, SEL_MIN, 24'($urandom_range(2) == 0 ? $urandom : $urandom_range(40000)));
    write(sp, SEL_SHIFT,
          24'($urandom_range(3) == 0 ? $urandom : $urandom_range(8192) - 4096));
    write(sp, SEL_MODE, 24'($urandom_range(4) == 0 ? $urandom : $urandom_range(200000, 1)));
    write(sp, SEL_SPREAD, 24'($urandom_range(4) == 0 ? $urandom : $urandom_range(8000, 1)));
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      logic [4:0] sp;
      sp = 5'($urandom);
      if ($urandom_range(9) == 0) load_row(sp);
      else if ($urandom_range(9) == 0) write(sp, psel_t'($urandom_range(3)), 24'($urandom));
      else if ($urandom_range(5) == 0) evaluate(sp, 23'($urandom));
      else evaluate(sp, 23'($urandom_range(120000)));
    end
  endtask

  initial begin
    foreach (written[i]) written[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, negative spread, invalid mode, zero spread, nonpositive sum
    write(0, SEL_MIN, 24'd4096);
    write(0, SEL_SHIFT, 24'd0);
    write(0, SEL_MODE, 24'd40960);
    write(0, SEL_SPREAD, 24'd2048);
    evaluate(0, 23'd0);
    evaluate(0, 23'd40960);
    evaluate(0, 23'h7FFFFF);
    write(1, SEL_MIN, 24'h800000);
    write(1, SEL_SHIFT, 24'h800000);
    write(1, SEL_MODE, 24'h7FFFFF);
    write(1, SEL_SPREAD, 24'hFFF000);
    evaluate(1, 23'd0);
    evaluate(1, 23'h7FFFFF);
    write(2, SEL_MIN, 24'h7FFFFF);
    write(2, SEL_SHIFT, 24'h7FFFFF);
    write(2, SEL_MODE, 24'h800000);
    write(2, SEL_SPREAD, 24'd0);
    evaluate(2, 23'd5);
    write(2, SEL_MODE, 24'd1);
    evaluate(2, 23'd5);
    write(2, SEL_SPREAD, 24'd1);
    evaluate(2, 23'd5);
    for (int s = 0; s < 32; s++) load_row(5'(s));
    random_phase(500);
    send_idle = 45;
    recv_idle = 8;
    random_phase(500);
    // hold off until the pipeline drains
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    send_idle = 0;
    recv_idle = 0;
    random_phase(500);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fail_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end
endmodule
